@@ rtl/point_obb_outside_distance_assert.svh @@
// Assertion macros shared by the point against oriented box block.
// Needs a signal named clock and a signal named reset in the using module.
`ifndef POINT_OBB_OUTSIDE_DISTANCE_ASSERT_SVH
`define POINT_OBB_OUTSIDE_DISTANCE_ASSERT_SVH

// Same-cycle implication, quiet during reset
`define POBD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet during reset
`define POBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/pobd_pkg.sv @@
// Types and constants of the point against oriented box block.
// No dependencies; used by every module in this folder.
package pobd_pkg;

   localparam int CoordW = 20;
   localparam int AxisW  = 16;
   localparam int DiffW  = 21;
   localparam int ProdW  = 37;
   localparam int ProjW  = 39;
   localparam int Prod2W = 55;
   localparam int AccW   = 57;
   localparam int SqW    = 40;
   localparam int SumW   = 42;
   localparam int CfgW   = 60;
   localparam int AxisRegW = 48;
   localparam int IndexW = 3;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [AxisW-1:0]  axis_type;
   typedef logic signed [ProjW-1:0]  excess_type;
   typedef logic [SqW-1:0]           square_type;

   // One rounded offset, travelling alongside the length computation
   typedef struct packed {
      logic      in_box;
      coord_type off_z;
      coord_type off_y;
      coord_type off_x;
   } res_type;

   typedef enum logic [IndexW-1:0] {
      REG_BOX_CENTER  = 3'd0,
      REG_BOX_HALF    = 3'd1,
      REG_AXIS_FIRST  = 3'd2,
      REG_AXIS_SECOND = 3'd3,
      REG_AXIS_THIRD  = 3'd4
   } reg_index_type;

   localparam logic [CfgW-1:0]     BoxCenterReset  = 60'd0;
   localparam logic [CfgW-1:0]     BoxHalfReset    = 60'd281475245146368;
   localparam logic [AxisRegW-1:0] AxisFirstReset  = 48'd16384;
   localparam logic [AxisRegW-1:0] AxisSecondReset = 48'd1073741824;
   localparam logic [AxisRegW-1:0] AxisThirdReset  = 48'd70368744177664;

endpackage

@@ rtl/pobd_proj.sv @@
// Projection pipeline: point minus centre, projection on each axis and
// the excess beyond the half extent. Depends on pobd_pkg.
module pobd_proj (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  pobd_pkg::coord_type point_x,
   input  pobd_pkg::coord_type point_y,
   input  pobd_pkg::coord_type point_z,
   input  logic [pobd_pkg::CfgW-1:0] center,
   input  logic [pobd_pkg::CfgW-1:0] half,
   input  logic [2:0][pobd_pkg::AxisRegW-1:0] axes,
   output logic out_valid,
   input  logic out_ready,
   output pobd_pkg::excess_type excess [3]
);

   logic [2:0] v_ff;
   logic [2:0] en;
   logic signed [pobd_pkg::DiffW-1:0] diff_ff [3];
   logic signed [pobd_pkg::DiffW-1:0] diff_in [3];
   logic signed [pobd_pkg::ProdW-1:0] prod_ff [3][3];
   logic signed [pobd_pkg::ProdW-1:0] prod_in [3][3];
   pobd_pkg::excess_type exc_ff [3];
   pobd_pkg::excess_type exc_in [3];
   pobd_pkg::axis_type axis_c [3][3];
   pobd_pkg::coord_type pt [3];

   // stall chain: a stage moves when empty or when the next one moves
   always_comb begin
      en[2] = !v_ff[2] || out_ready;
      en[1] = !v_ff[1] || en[2];
      en[0] = !v_ff[0] || en[1];
   end
   assign in_ready  = en[0];
   assign out_valid = v_ff[2];

   always_comb begin
      pt[0] = point_x;
      pt[1] = point_y;
      pt[2] = point_z;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            axis_c[i][k] = pobd_pkg::axis_type'(axes[i][k*pobd_pkg::AxisW +: pobd_pkg::AxisW]);
         end
      end
   end

   // stage 1: difference to the centre
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff_in[k] = pobd_pkg::DiffW'(pt[k])
            - pobd_pkg::DiffW'(pobd_pkg::coord_type'(
                 center[k*pobd_pkg::CoordW +: pobd_pkg::CoordW]));
      end
   end

   // stage 2: component products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[i][k] = diff_ff[k] * axis_c[i][k];
         end
      end
   end

   // stage 3: projection sum and signed excess over the half extent
   always_comb begin
      logic signed [pobd_pkg::ProjW-1:0] d;
      logic signed [pobd_pkg::ProjW-1:0] mag;
      logic signed [pobd_pkg::ProjW-1:0] h;
      for (int i = 0; i < 3; i++) begin
         d = pobd_pkg::ProjW'(prod_ff[i][0]) + pobd_pkg::ProjW'(prod_ff[i][1])
           + pobd_pkg::ProjW'(prod_ff[i][2]);
         mag = d[pobd_pkg::ProjW-1] ? -d : d;
         h = $signed({5'd0, half[i*pobd_pkg::CoordW +: pobd_pkg::CoordW], 14'd0});
         if (mag > h) begin
            exc_in[i] = d[pobd_pkg::ProjW-1] ? h - mag : mag - h;
         end else begin
            exc_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) diff_ff <= diff_in;
      if (en[1]) prod_ff <= prod_in;
      if (en[2]) exc_ff  <= exc_in;
   end

   assign excess = exc_ff;

endmodule

@@ rtl/pobd_offset.sv @@
// Offset pipeline: excess times axis, summed, rounded and saturated, then
// squared for the length. Depends on pobd_pkg.
module pobd_offset (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  pobd_pkg::excess_type excess [3],
   input  logic [2:0][pobd_pkg::AxisRegW-1:0] axes,
   output logic out_valid,
   input  logic out_ready,
   output pobd_pkg::res_type res,
   output pobd_pkg::square_type square [3]
);

   logic [2:0] v_ff;
   logic [2:0] en;
   logic signed [pobd_pkg::Prod2W-1:0] prod_ff [3][3];
   logic signed [pobd_pkg::Prod2W-1:0] prod_in [3][3];
   pobd_pkg::res_type res1_ff, res1_in, res2_ff;
   pobd_pkg::square_type sq_ff [3];
   pobd_pkg::square_type sq_in [3];
   pobd_pkg::axis_type axis_c [3][3];

   // round to nearest, ties away from zero, then clamp to the coordinate range
   function automatic pobd_pkg::coord_type round_sat(
      input logic signed [pobd_pkg::AccW-1:0] v);
      logic neg;
      logic [pobd_pkg::AccW-1:0] u;
      logic [pobd_pkg::AccW-1:0] q;
      logic [pobd_pkg::CoordW-1:0] m;
      neg = v[pobd_pkg::AccW-1];
      u = neg ? pobd_pkg::AccW'(-v) : pobd_pkg::AccW'(v);
      q = (u + (pobd_pkg::AccW'(1) << 27)) >> 28;
      if (neg) begin
         m = (q > pobd_pkg::AccW'(524288)) ? 20'h80000 : q[pobd_pkg::CoordW-1:0];
         return pobd_pkg::coord_type'(~m + 20'd1);
      end
      m = (q > pobd_pkg::AccW'(524287)) ? 20'h7FFFF : q[pobd_pkg::CoordW-1:0];
      return pobd_pkg::coord_type'(m);
   endfunction

   always_comb begin
      en[2] = !v_ff[2] || out_ready;
      en[1] = !v_ff[1] || en[2];
      en[0] = !v_ff[0] || en[1];
   end
   assign in_ready  = en[0];
   assign out_valid = v_ff[2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            axis_c[i][k] = pobd_pkg::axis_type'(axes[i][k*pobd_pkg::AxisW +: pobd_pkg::AxisW]);
         end
      end
   end

   // stage 1: contribution of each axis to each coordinate
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[i][k] = excess[i] * axis_c[i][k];
         end
      end
   end

   // stage 2: exact sums, zero test, rounding
   always_comb begin
      logic signed [pobd_pkg::AccW-1:0] acc [3];
      for (int k = 0; k < 3; k++) begin
         acc[k] = pobd_pkg::AccW'(prod_ff[0][k]) + pobd_pkg::AccW'(prod_ff[1][k])
                + pobd_pkg::AccW'(prod_ff[2][k]);
      end
      res1_in.in_box = (acc[0] == '0) && (acc[1] == '0) && (acc[2] == '0);
      res1_in.off_x  = round_sat(acc[0]);
      res1_in.off_y  = round_sat(acc[1]);
      res1_in.off_z  = round_sat(acc[2]);
   end

   // stage 3: squares of the rounded offsets
   always_comb begin
      logic signed [pobd_pkg::SqW-1:0] s [3];
      s[0] = res1_ff.off_x * res1_ff.off_x;
      s[1] = res1_ff.off_y * res1_ff.off_y;
      s[2] = res1_ff.off_z * res1_ff.off_z;
      for (int k = 0; k < 3; k++) sq_in[k] = pobd_pkg::square_type'(s[k]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) prod_ff <= prod_in;
      if (en[1]) res1_ff <= res1_in;
      if (en[2]) begin
         res2_ff <= res1_ff;
         sq_ff   <= sq_in;
      end
   end

   assign res    = res2_ff;
   assign square = sq_ff;

endmodule

@@ rtl/pobd_root.sv @@
// Length pipeline: sum of squares, one square root bit per stage, rounding.
// Carries the offset result alongside. Depends on pobd_pkg.
module pobd_root (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  pobd_pkg::res_type res_i,
   input  pobd_pkg::square_type square [3],
   output logic out_valid,
   input  logic out_ready,
   output pobd_pkg::res_type res_o,
   output logic [pobd_pkg::CoordW-1:0] distance
);

   localparam int Steps  = pobd_pkg::SumW / 2;
   localparam int Stages = Steps + 2;

   logic [Stages-1:0] v_ff;
   logic [Stages-1:0] en;
   logic [pobd_pkg::SumW-1:0] x_ff [Steps+1];
   logic [pobd_pkg::SumW-1:0] r_ff [Steps+1];
   logic [pobd_pkg::SumW-1:0] x_in [Steps+1];
   logic [pobd_pkg::SumW-1:0] r_in [Steps+1];
   pobd_pkg::res_type pay_ff [Stages];
   logic [pobd_pkg::CoordW-1:0] dist_ff, dist_in;

   // stall chain from the output back to the input
   always_comb begin
      en[Stages-1] = !v_ff[Stages-1] || out_ready;
      for (int s = Stages - 2; s >= 0; s--) en[s] = !v_ff[s] || en[s+1];
   end
   assign in_ready  = en[0];
   assign out_valid = v_ff[Stages-1];

   // stage 0: sum of squares
   always_comb begin
      x_in[0] = pobd_pkg::SumW'(square[0]) + pobd_pkg::SumW'(square[1])
              + pobd_pkg::SumW'(square[2]);
      r_in[0] = '0;
   end

   // one digit of the root per stage
   for (genvar s = 1; s <= Steps; s++) begin : g_step
      localparam logic [pobd_pkg::SumW-1:0] Bit =
         pobd_pkg::SumW'(1) << (pobd_pkg::SumW - 2 * s);
      always_comb begin
         logic [pobd_pkg::SumW-1:0] t;
         t = r_ff[s-1] + Bit;
         if (x_ff[s-1] >= t) begin
            x_in[s] = x_ff[s-1] - t;
            r_in[s] = (r_ff[s-1] >> 1) + Bit;
         end else begin
            x_in[s] = x_ff[s-1];
            r_in[s] = r_ff[s-1] >> 1;
         end
      end
   end

   // last stage: round up when the remainder exceeds the root
   always_comb begin
      logic [pobd_pkg::SumW-1:0] r;
      r = r_ff[Steps] + ((x_ff[Steps] > r_ff[Steps]) ? pobd_pkg::SumW'(1) : '0);
      dist_in = r[pobd_pkg::CoordW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         for (int s = 1; s < Stages; s++) begin
            if (en[s]) v_ff[s] <= v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) pay_ff[0] <= res_i;
      for (int s = 1; s < Stages; s++) begin
         if (en[s]) pay_ff[s] <= pay_ff[s-1];
      end
      for (int s = 0; s <= Steps; s++) begin
         if (en[s]) begin
            x_ff[s] <= x_in[s];
            r_ff[s] <= r_in[s];
         end
      end
      if (en[Stages-1]) dist_ff <= dist_in;
   end

   assign res_o    = pay_ff[Stages-1];
   assign distance = dist_ff;

endmodule

@@ rtl/point_obb_outside_distance.sv @@
// Point against oriented box: offset from the nearest box point and length.
// A request on req_ carries one point (x, y, z, signed Q12.8). The response
// on rsp_ carries the offset vector, its length and an inside flag in tuser.
// Box registers (centre, half extents, three axes) are written through the
// csr_ port; the user writes only while no request is in flight, unchecked.
// From request to response there are 3 stages of projection, 3 of offset
// and squaring, and 23 for the length (sum of squares, 21 root stages of
// one bit each, rounding).
// Throughput is one request per cycle while rsp_tready stays high; the
// 23-stage length pipeline sets the depth, not the rate.
// While rsp_tready is low the pipeline keeps its results and closes up
// empty stages, so requests are still taken until every stage is full.
// Reset empties the pipeline and restores the unit box at the origin with
// half extents 1.0 and axes along x, y and z.
// Depends on pobd_pkg, pobd_proj, pobd_offset, pobd_root and the assert header.
`include "point_obb_outside_distance_assert.svh"

module point_obb_outside_distance (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // point_x, point_y, point_z, zero pad
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // offset_x, offset_y, offset_z, distance
   output logic        rsp_tuser,   // inside_res
   // register writes
   input  logic        csr_wen,
   input  logic [pobd_pkg::IndexW-1:0] csr_index,
   input  logic [pobd_pkg::CfgW-1:0]   csr_wdata
);

   logic [pobd_pkg::CfgW-1:0]     box_center_ff, box_half_ff;
   logic [pobd_pkg::AxisRegW-1:0] axis_first_ff, axis_second_ff, axis_third_ff;
   logic [2:0][pobd_pkg::AxisRegW-1:0] axes;
   logic proj_valid, proj_ready, offs_valid, offs_ready;
   pobd_pkg::excess_type excess [3];
   pobd_pkg::res_type offs_res, root_res;
   pobd_pkg::square_type square [3];
   logic [pobd_pkg::CoordW-1:0] distance;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         box_center_ff  <= pobd_pkg::BoxCenterReset;
         box_half_ff    <= pobd_pkg::BoxHalfReset;
         axis_first_ff  <= pobd_pkg::AxisFirstReset;
         axis_second_ff <= pobd_pkg::AxisSecondReset;
         axis_third_ff  <= pobd_pkg::AxisThirdReset;
      end else if (csr_wen) begin
         unique case (pobd_pkg::reg_index_type'(csr_index))
            pobd_pkg::REG_BOX_CENTER:  box_center_ff  <= csr_wdata;
            pobd_pkg::REG_BOX_HALF:    box_half_ff    <= csr_wdata;
            pobd_pkg::REG_AXIS_FIRST:  axis_first_ff  <= csr_wdata[pobd_pkg::AxisRegW-1:0];
            pobd_pkg::REG_AXIS_SECOND: axis_second_ff <= csr_wdata[pobd_pkg::AxisRegW-1:0];
            pobd_pkg::REG_AXIS_THIRD:  axis_third_ff  <= csr_wdata[pobd_pkg::AxisRegW-1:0];
            default: ;
         endcase
      end
   end

   assign axes = {axis_third_ff, axis_second_ff, axis_first_ff};

   pobd_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .point_x   (pobd_pkg::coord_type'(req_tdata[19:0])),
      .point_y   (pobd_pkg::coord_type'(req_tdata[39:20])),
      .point_z   (pobd_pkg::coord_type'(req_tdata[59:40])),
      .center    (box_center_ff),
      .half      (box_half_ff),
      .axes      (axes),
      .out_valid (proj_valid),
      .out_ready (proj_ready),
      .excess    (excess)
   );

   pobd_offset u_offset (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (proj_valid),
      .in_ready  (proj_ready),
      .excess    (excess),
      .axes      (axes),
      .out_valid (offs_valid),
      .out_ready (offs_ready),
      .res       (offs_res),
      .square    (square)
   );

   pobd_root u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (offs_valid),
      .in_ready  (offs_ready),
      .res_i     (offs_res),
      .square    (square),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .res_o     (root_res),
      .distance  (distance)
   );

   assign rsp_tdata = {distance, root_res.off_z, root_res.off_y, root_res.off_x};
   assign rsp_tuser = root_res.in_box;

   // an inside point has no offset and no length
   `POBD_ASSERT_NOW(a_inside_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0,
      "inside response with nonzero offset or length")
   // zero offset gives zero length
   `POBD_ASSERT_NOW(a_zero_len, rsp_tvalid && (rsp_tdata[59:0] == '0),
      rsp_tdata[79:60] == '0, "zero offset with nonzero length")
   // a centre write lands in the register
   `POBD_ASSERT_NEXT(a_center_wr,
      csr_wen && (csr_index == pobd_pkg::REG_BOX_CENTER),
      box_center_ff == $past(csr_wdata), "centre register write lost")

endmodule

@@ tb/tb.sv @@
// Self-checking bench for point_obb_outside_distance: point queries against a
// configured oriented box, compared with a behavioural predictor in this file.
// Depends on pobd_pkg and the block's RTL.
module tb;

   localparam int Latency = 29;
   localparam longint CycleLimit = 400000;

   typedef struct packed {
      logic              in_box;
      logic [19:0]       off_x;
      logic [19:0]       off_y;
      logic [19:0]       off_z;
      logic [19:0]       length;
   } box_result_type;

   typedef struct {
      logic [19:0] px;
      logic [19:0] py;
      logic [19:0] pz;
      bit          known;    // expected result typed in below
      box_result_type want;
   } point_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wen;
   logic [pobd_pkg::IndexW-1:0] csr_index;
   logic [pobd_pkg::CfgW-1:0]   csr_wdata;

   // local copy of the box registers
   logic [59:0] centre_reg, half_reg;
   logic [47:0] axis_reg [3];

   box_result_type pending_results [$];
   int mismatches;
   longint cycles;
   bit hold_off;
   bit stall_on;

   point_obb_outside_distance dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // rounds Q.36 to Q.8, ties away from zero, then saturates
   function automatic longint round_to_coord(longint v);
      longint u, q;
      u = (v < 0) ? -v : v;
      q = (u + (64'sd1 <<< 27)) >>> 28;
      if (v < 0) begin
         if (q > 524288) q = 524288;
         return -q;
      end
      if (q > 524287) q = 524287;
      return q;
   endfunction

   function automatic longint round_sqrt(longint s);
      longint r;
      r = longint'($floor($sqrt(real'(s))));
      while (r * r > s) r--;
      while ((r + 1) * (r + 1) <= s) r++;
      if (s - r * r > r) r++;
      return r;
   endfunction

   function automatic box_result_type predict_offset(logic [19:0] px, logic [19:0] py,
                                                     logic [19:0] pz);
      box_result_type o;
      longint rel [3];
      longint acc [3];
      longint comp [3];
      longint d, h, mag, e, sq;
      logic [19:0] pt [3];
      longint r [3];
      pt[0] = px; pt[1] = py; pt[2] = pz;
      acc = '{0, 0, 0};
      for (int k = 0; k < 3; k++)
         rel[k] = longint'(signed'(pt[k])) - longint'(signed'(centre_reg[20*k +: 20]));
      for (int i = 0; i < 3; i++) begin
         d = 0;
         h = longint'(half_reg[20*i +: 20]) <<< 14;
         for (int k = 0; k < 3; k++) begin
            comp[k] = longint'(signed'(axis_reg[i][16*k +: 16]));
            d += rel[k] * comp[k];
         end
         mag = (d < 0) ? -d : d;
         if (mag > h) begin
            e = (d < 0) ? h - mag : mag - h;
            for (int k = 0; k < 3; k++) acc[k] += e * comp[k];
         end
      end
      sq = 0;
      for (int k = 0; k < 3; k++) begin
         r[k] = round_to_coord(acc[k]);
         sq += r[k] * r[k];
      end
      o.in_box = (acc[0] == 0) && (acc[1] == 0) && (acc[2] == 0);
      o.off_x  = r[0][19:0];
      o.off_y  = r[1][19:0];
      o.off_z  = r[2][19:0];
      o.length = 20'(round_sqrt(sq));
      return o;
   endfunction

   task automatic write_reg(pobd_pkg::reg_index_type idx, logic [59:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (idx)
         pobd_pkg::REG_BOX_CENTER:  centre_reg = val;
         pobd_pkg::REG_BOX_HALF:    half_reg = val;
         pobd_pkg::REG_AXIS_FIRST:  axis_reg[0] = val[47:0];
         pobd_pkg::REG_AXIS_SECOND: axis_reg[1] = val[47:0];
         pobd_pkg::REG_AXIS_THIRD:  axis_reg[2] = val[47:0];
         default: ;
      endcase
   endtask

   // called at a falling edge; returns at a falling edge after acceptance
   task automatic send_point(logic [19:0] px, logic [19:0] py, logic [19:0] pz);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, pz, py, px};
      pending_results.push_back(predict_offset(px, py, pz));
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_gap();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [19:0] rand_coord(int span);
      if (span == 0) return 20'($urandom);
      return 20'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(0, 3))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'd0;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_box(bit wide);
      logic [59:0] c, h;
      logic [47:0] a;
      c = {rand_coord(wide ? 0 : 2000), rand_coord(wide ? 0 : 2000),
           rand_coord(wide ? 0 : 2000)};
      h = {20'($urandom_range(0, wide ? 1048575 : 1500)),
           20'($urandom_range(0, wide ? 1048575 : 1500)),
           20'($urandom_range(0, wide ? 1048575 : 1500))};
      write_reg(pobd_pkg::REG_BOX_CENTER, c);
      write_reg(pobd_pkg::REG_BOX_HALF, h);
      for (int i = 0; i < 3; i++) begin
         a = {rand_axis(), rand_axis(), rand_axis()};
         write_reg(pobd_pkg::reg_index_type'(pobd_pkg::REG_AXIS_FIRST + i), {12'd0, a});
      end
   endtask

   // response check at the rising edge
   always @(posedge clock) begin
      box_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.in_box = rsp_tuser;
         got.off_x  = rsp_tdata[19:0];
         got.off_y  = rsp_tdata[39:20];
         got.off_z  = rsp_tdata[59:40];
         got.length = rsp_tdata[79:60];
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h/%b", rsp_tdata, rsp_tuser);
         end else begin
            want = pending_results.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want in=%b x=%h y=%h z=%h d=%h got in=%b x=%h y=%h z=%h d=%h",
                     want.in_box, want.off_x, want.off_y, want.off_z, want.length,
                     got.in_box, got.off_x, got.off_y, got.off_z, got.length);
            end
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (120) @(negedge clock);
            hold_off = 1'b0;
         end else if (stall_on)
            rsp_tready <= ($urandom_range(0, 3) != 0);
         else
            rsp_tready <= 1'b1;
      end
   end

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      point_row_type rows [10];
      point_row_type row;
      int n_sent;
      int burst;
      rows = '{
         '{20'd0, 20'd0, 20'd0, 1, '{1'b1, 20'd0, 20'd0, 20'd0, 20'd0}},
         '{20'd256, 20'd0, 20'd0, 1, '{1'b1, 20'd0, 20'd0, 20'd0, 20'd0}},
         '{20'd512, 20'd0, 20'd0, 1, '{1'b0, 20'd256, 20'd0, 20'd0, 20'd256}},
         '{20'd0, -20'sd512, 20'd0, 1, '{1'b0, 20'd0, -20'sd256, 20'd0, 20'd256}},
         '{20'd0, 20'd0, 20'd257, 1, '{1'b0, 20'd0, 20'd0, 20'd1, 20'd1}},
         '{20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 0, '{default: '0}},
         '{20'h80000, 20'h80000, 20'h80000, 0, '{default: '0}},
         '{20'h80000, 20'h7FFFF, 20'h00000, 0, '{default: '0}},
         '{20'd768, 20'd768, 20'd0, 0, '{default: '0}},
         '{20'hFFFFF, 20'd1, 20'hFFF00, 0, '{default: '0}}
      };
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0;
      csr_wen = 1'b0; csr_index = '0; csr_wdata = '0;
      hold_off = 1'b0; stall_on = 1'b0; mismatches = 0;
      centre_reg = pobd_pkg::BoxCenterReset; half_reg = pobd_pkg::BoxHalfReset;
      axis_reg[0] = pobd_pkg::AxisFirstReset; axis_reg[1] = pobd_pkg::AxisSecondReset;
      axis_reg[2] = pobd_pkg::AxisThirdReset;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table at reset box
      foreach (rows[i]) begin
         row = rows[i];
         send_point(row.px, row.py, row.pz);
         if (row.known) begin
            void'(pending_results.pop_back());
            pending_results.push_back(row.want);
         end
      end
      drain();
      repeat (Latency) @(negedge clock);

      // zero half extents, non-unit and cancelling axes, extreme box
      write_reg(pobd_pkg::REG_BOX_HALF, 60'd0);
      write_reg(pobd_pkg::REG_AXIS_SECOND, {16'd0, 16'd0, 16'sd16384});
      send_point(20'd1, 20'd0, 20'd0);
      send_point(20'd0, 20'd0, 20'd0);
      drain();
      write_reg(pobd_pkg::REG_AXIS_FIRST, {16'h8000, 16'h8000, 16'h8000});
      write_reg(pobd_pkg::REG_AXIS_SECOND, {16'h7FFF, 16'h7FFF, 16'h7FFF});
      write_reg(pobd_pkg::REG_AXIS_THIRD, {16'hFFFF, 16'h0001, 16'h0000});
      write_reg(pobd_pkg::REG_BOX_CENTER, {20'h80000, 20'h7FFFF, 20'h80000});
      send_point(20'h7FFFF, 20'h80000, 20'h7FFFF);
      send_point(20'h00001, 20'h00000, 20'h00000);
      send_point(20'h80000, 20'h7FFFF, 20'h80000);
      drain();
      write_reg(pobd_pkg::REG_BOX_HALF, 60'hFFFFFFFFFFFFFFF);
      send_point(20'h7FFFF, 20'h80000, 20'h7FFFF);
      send_point(20'h12345, 20'hABCDE, 20'h55555);
      drain();
      // index beyond the register set
      write_reg(pobd_pkg::reg_index_type'(3'd7), 60'd5);

      // random phases, new box each phase
      stall_on = 1'b1;
      n_sent = 0;
      for (int phase = 0; phase < 20; phase++) begin
         random_box(phase % 4 == 3);
         if (phase == 5) hold_off = 1'b1;
         for (int j = 0; j < 50; j += burst) begin
            burst = $urandom_range(1, 12);
            if (phase % 3 == 0) stall_on = 1'b0; else stall_on = 1'b1;
            for (int b = 0; b < burst; b++) begin
               if (phase % 4 == 3)
                  send_point(rand_coord(0), rand_coord(0), rand_coord(0));
               else
                  send_point(rand_coord(3000), rand_coord(3000), rand_coord(3000));
               n_sent++;
            end
            if ($urandom_range(0, 2) != 0) send_gap();
         end
         drain();
      end

      repeat (Latency + 10) @(negedge clock);
      $display("covered %0d random points over 20 box settings plus directed corners",
               n_sent);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
